// ===== sv/hcs_pkg.sv =====
// Shared types and constants for the min-max contrast stretch block.
// No dependencies; used by hcs_ctrl, hcs_datapath and the top level.
`default_nettype none

package hcs_pkg;

  localparam int unsigned PixW  = 8;
  localparam int unsigned QuoW  = 8;
  localparam int unsigned DenW  = PixW + 1;
  localparam int unsigned NumW  = DenW + QuoW;
  localparam int unsigned UserW = 2;
  localparam int unsigned CntW  = $clog2(QuoW);

  localparam logic [PixW-1:0] PixMax = '1;
  localparam logic [PixW-1:0] PixMin = '0;

  localparam logic ActMeasure = 1'b0;
  localparam logic ActStretch = 1'b1;

  typedef struct packed {
    logic measure;
    logic prep;
    logic div_step;
    logic out_load;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/histogram_contrast_stretch_core.sv =====
// Min-max contrast stretch of 8-bit pixels: measure requests update the frame
// minimum and maximum registers and are taken back to back with no result.
// A stretch request yields its result after a setup state, the eight-step
// restoring divider and an output state; the next request is taken once the
// stretch result is loaded into the output register, later if the output stalls.
// Reset (rst_ni low, asynchronous) sets min to 255 and max to 0, clears valid.
`default_nettype none

module histogram_contrast_stretch_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] pixel
  input  wire logic [1:0]  s_axis_tuser,   // [0] action, [1] first_of_frame
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata    // [7:0] stretched_pixel
);

  hcs_pkg::cmd_t cmd;
  logic          accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  hcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser[0]),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  hcs_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .pixel_i      (s_axis_tdata),
    .first_i      (s_axis_tuser[1]),
    .load_pixel_i (accept),
    .result_o     (m_axis_tdata)
  );

  a_stretch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (s_axis_tuser[0] == hcs_pkg::ActStretch) |=> !s_axis_tready)
    else $error("request taken while a stretch is in progress");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> m_axis_tvalid)
    else $error("result loaded without valid");

  a_div_no_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.div_step || cmd.prep) |-> !s_axis_tready)
    else $error("input ready while divider is running");

endmodule

`default_nettype wire

// ===== sv/hcs_ctrl.sv =====
// Controller state machine for the contrast stretch block.
// Depends on hcs_pkg; drives commands into hcs_datapath and the stream handshakes.
`default_nettype none

module hcs_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic                      in_action_i,
  output logic                           in_ready_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output hcs_pkg::cmd_t                  cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StPrep,
    StDiv,
    StFin
  } state_e;

  state_e                    state_q;
  logic [hcs_pkg::CntW-1:0]  cnt_q;
  logic                      out_valid_q;
  logic                      accept;
  logic                      out_free;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.measure  = accept && (in_action_i == hcs_pkg::ActMeasure);
    cmd_o.prep     = (state_q == StPrep);
    cmd_o.div_step = (state_q == StDiv);
    cmd_o.out_load = (state_q == StFin) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_o.out_load || (out_valid_q && !out_ready_i);
      case (state_q)
        StIdle: begin
          if (accept && (in_action_i == hcs_pkg::ActStretch)) begin
            state_q <= StPrep;
          end
        end
        StPrep: begin
          cnt_q   <= '0;
          state_q <= StDiv;
        end
        StDiv: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == hcs_pkg::CntW'(hcs_pkg::QuoW - 1)) begin
            state_q <= StFin;
          end
        end
        StFin: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/hcs_datapath.sv =====
// Datapath for the contrast stretch block: frame statistics, restoring divider
// and output register. Depends on hcs_pkg; commanded by hcs_ctrl.
`default_nettype none

module hcs_datapath (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire hcs_pkg::cmd_t             cmd_i,
  input  wire logic [hcs_pkg::PixW-1:0]  pixel_i,
  input  wire logic                      first_i,
  input  wire logic                      load_pixel_i,
  output logic [hcs_pkg::PixW-1:0]       result_o
);

  logic [hcs_pkg::PixW-1:0] min_q, max_q, pix_q, out_q, bypv_q;
  logic [hcs_pkg::DenW-1:0] den_q, rem_q;
  logic [hcs_pkg::QuoW-1:0] quo_q;
  logic                     byp_q;

  logic [hcs_pkg::PixW-1:0] diff, range;
  logic [hcs_pkg::NumW-1:0] num;
  logic [hcs_pkg::DenW:0]   trial;
  logic                     ge;
  logic                     flat, below, above;

  always_comb begin
    diff  = pix_q - min_q;
    range = max_q - min_q;
    num   = ({diff, 9'b0} - {8'b0, diff, 1'b0}) + {9'b0, range};
    trial = {rem_q, quo_q[hcs_pkg::QuoW-1]};
    ge    = trial >= {1'b0, den_q};
    flat  = max_q <= min_q;
    below = pix_q <= min_q;
    above = pix_q >= max_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= hcs_pkg::PixMax;
      max_q <= hcs_pkg::PixMin;
    end else if (cmd_i.measure) begin
      if (first_i) begin
        min_q <= pixel_i;
        max_q <= pixel_i;
      end else begin
        if (pixel_i < min_q) begin
          min_q <= pixel_i;
        end
        if (pixel_i > max_q) begin
          max_q <= pixel_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_pixel_i) begin
      pix_q <= pixel_i;
    end
    if (cmd_i.prep) begin
      den_q <= {range, 1'b0};
      rem_q <= num[hcs_pkg::NumW-1:hcs_pkg::QuoW];
      quo_q <= num[hcs_pkg::QuoW-1:0];
      byp_q <= flat || below || above;
      if (flat) begin
        bypv_q <= pix_q;
      end else if (below) begin
        bypv_q <= hcs_pkg::PixMin;
      end else begin
        bypv_q <= hcs_pkg::PixMax;
      end
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? hcs_pkg::DenW'(trial - {1'b0, den_q}) : trial[hcs_pkg::DenW-1:0];
      quo_q <= {quo_q[hcs_pkg::QuoW-2:0], ge};
    end
    if (cmd_i.out_load) begin
      out_q <= byp_q ? bypv_q : quo_q;
    end
  end

  assign result_o = out_q;

endmodule

`default_nettype wire

// ===== tb/sv/histogram_contrast_stretch_core_tb.sv =====
// Testbench for histogram_contrast_stretch_core: measure and stretch requests go in
// on the input stream, and stretched pixels are checked against an in-bench predictor.
// Depends on hcs_pkg and the core; needs no files or arguments.
`timescale 1ns / 100ps
`default_nettype none

module histogram_contrast_stretch_core_tb;

  typedef struct packed {
    logic                     act;
    logic [hcs_pkg::PixW-1:0] pix;
    logic                     fof;
    logic                     known;
    logic [hcs_pkg::PixW-1:0] want;
  } probe_row_t;

  localparam int unsigned NumProbes   = 25;
  localparam int unsigned RandomItems = 1625;

  // Directed requests: rows with known set carry an expected value that needs no predictor.
  localparam probe_row_t ProbeRows [NumProbes] = '{
    '{hcs_pkg::ActStretch, 8'd0,   1'b0, 1'b1, 8'd0},
    '{hcs_pkg::ActStretch, 8'd255, 1'b0, 1'b1, 8'd255},
    '{hcs_pkg::ActStretch, 8'd77,  1'b0, 1'b1, 8'd77},
    '{hcs_pkg::ActMeasure, 8'd200, 1'b0, 1'b0, 8'd0},
    '{hcs_pkg::ActStretch, 8'd200, 1'b0, 1'b1, 8'd200},
    '{hcs_pkg::ActMeasure, 8'd50,  1'b0, 1'b0, 8'd0},
    '{hcs_pkg::ActStretch, 8'd50,  1'b0, 1'b1, 8'd0},
    '{hcs_pkg::ActStretch, 8'd200, 1'b0, 1'b1, 8'd255},
    '{hcs_pkg::ActStretch, 8'd10,  1'b0, 1'b1, 8'd0},
    '{hcs_pkg::ActStretch, 8'd250, 1'b0, 1'b1, 8'd255},
    '{hcs_pkg::ActStretch, 8'd125, 1'b0, 1'b0, 8'd0},
    '{hcs_pkg::ActMeasure, 8'd0,   1'b1, 1'b0, 8'd0},
    '{hcs_pkg::ActMeasure, 8'd255, 1'b0, 1'b0, 8'd0},
    '{hcs_pkg::ActStretch, 8'd0,   1'b0, 1'b1, 8'd0},
    '{hcs_pkg::ActStretch, 8'd255, 1'b0, 1'b1, 8'd255},
    '{hcs_pkg::ActStretch, 8'd128, 1'b0, 1'b0, 8'd0},
    '{hcs_pkg::ActMeasure, 8'd100, 1'b1, 1'b0, 8'd0},
    '{hcs_pkg::ActStretch, 8'd100, 1'b0, 1'b1, 8'd100},
    '{hcs_pkg::ActStretch, 8'd3,   1'b0, 1'b1, 8'd3},
    '{hcs_pkg::ActMeasure, 8'd101, 1'b0, 1'b0, 8'd0},
    '{hcs_pkg::ActStretch, 8'd100, 1'b0, 1'b1, 8'd0},
    '{hcs_pkg::ActStretch, 8'd101, 1'b0, 1'b1, 8'd255},
    '{hcs_pkg::ActStretch, 8'd255, 1'b0, 1'b1, 8'd255},
    '{hcs_pkg::ActStretch, 8'd101, 1'b1, 1'b1, 8'd255},
    '{hcs_pkg::ActStretch, 8'd100, 1'b0, 1'b1, 8'd0}
  };

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [7:0]      s_axis_tdata  = '0;  // [7:0] pixel
  logic [1:0]      s_axis_tuser  = '0;  // [0] action, [1] first_of_frame
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [7:0]      m_axis_tdata;        // [7:0] stretched_pixel

  logic [hcs_pkg::PixW-1:0] frame_lo = hcs_pkg::PixMax;
  logic [hcs_pkg::PixW-1:0] frame_hi = hcs_pkg::PixMin;
  logic [hcs_pkg::PixW-1:0] expected_pixels [$];
  int unsigned              mismatch_count = 0;
  int unsigned              items_sent     = 0;
  bit                       sender_steady  = 1'b0;

  histogram_contrast_stretch_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [hcs_pkg::PixW-1:0] stretch_predict(
      logic [hcs_pkg::PixW-1:0] pix);
    int unsigned span;
    int unsigned offset;
    int unsigned quo;
    if (frame_hi <= frame_lo) return pix;
    if (pix <= frame_lo) return hcs_pkg::PixMin;
    span   = 32'(frame_hi) - 32'(frame_lo);
    offset = 32'(pix) - 32'(frame_lo);
    quo    = (2 * offset * int'(hcs_pkg::PixMax) + span) / (2 * span);
    if (quo > int'(hcs_pkg::PixMax)) quo = int'(hcs_pkg::PixMax);
    return quo[hcs_pkg::PixW-1:0];
  endfunction

  function automatic void fold_pixel(logic [hcs_pkg::PixW-1:0] pix, logic fof);
    if (fof) begin
      frame_lo = pix;
      frame_hi = pix;
    end else begin
      if (pix < frame_lo) frame_lo = pix;
      if (pix > frame_hi) frame_hi = pix;
    end
  endfunction

  task automatic send_request(input logic act, input logic [hcs_pkg::PixW-1:0] pix,
                              input logic fof, input logic known,
                              input logic [hcs_pkg::PixW-1:0] want);
    while (!sender_steady && $urandom_range(99) < 20) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= {fof, act};
    do @(posedge clk_i); while (!s_axis_tready);
    if (act == hcs_pkg::ActStretch) begin
      expected_pixels = {expected_pixels, (known ? want : stretch_predict(pix))};
    end else begin
      fold_pixel(pix, fof);
    end
    items_sent++;
  endtask

  // One frame: a measure pass that opens with a first-of-frame request, then a
  // stretch pass. Pixels mostly fall in a random window so that narrow and flat
  // ranges come up often.
  task automatic run_frame();
    int unsigned lo;
    int unsigned hi;
    int unsigned n_measure;
    int unsigned n_stretch;
    logic [hcs_pkg::PixW-1:0] pix;
    lo = $urandom_range(255);
    hi = ($urandom_range(9) == 0) ? lo : $urandom_range(255, lo);
    n_measure = $urandom_range(12, 1);
    n_stretch = $urandom_range(12, 1);
    for (int unsigned i = 0; i < n_measure; i++) begin
      pix = hcs_pkg::PixW'($urandom_range(hi, lo));
      send_request(hcs_pkg::ActMeasure, pix, (i == 0), 1'b0, '0);
    end
    for (int unsigned i = 0; i < n_stretch; i++) begin
      pix = hcs_pkg::PixW'(($urandom_range(4) == 0) ? $urandom_range(255)
                                                    : $urandom_range(hi, lo));
      send_request(hcs_pkg::ActStretch, pix, 1'($urandom_range(1)), 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    int unsigned noise_len;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int unsigned i = 0; i < NumProbes; i++) begin
      send_request(ProbeRows[i].act, ProbeRows[i].pix, ProbeRows[i].fof,
                   ProbeRows[i].known, ProbeRows[i].want);
    end
    while (items_sent < NumProbes + RandomItems) begin
      sender_steady = (items_sent >= 700 && items_sent < 900);
      if ($urandom_range(99) < 15) begin
        noise_len = $urandom_range(8, 1);
        for (int unsigned i = 0; i < noise_len; i++) begin
          send_request(1'($urandom_range(1)), hcs_pkg::PixW'($urandom_range(255)),
                       1'($urandom_range(1)), 1'b0, '0);
        end
      end else begin
        run_frame();
      end
    end
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result side: checks each accepted result and drives tready, with two long
  // hold-offs so that the core fills up and stalls its input.
  initial begin : result_sink
    int unsigned holdoff;
    int unsigned results_seen;
    logic [hcs_pkg::PixW-1:0] want;
    holdoff      = 0;
    results_seen = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pixels.size() == 0) begin
          $error("stretched_pixel: no result expected, actual %0d", m_axis_tdata);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (m_axis_tdata !== want) begin
            $error("stretched_pixel: expected %0d, actual %0d", want, m_axis_tdata);
            mismatch_count++;
          end
        end
        results_seen++;
        if (results_seen == 40 || results_seen == 500) holdoff = 120;
      end
      if (holdoff > 0) begin
        holdoff--;
        m_axis_tready <= 1'b0;
      end else if (results_seen >= 250 && results_seen < 350) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 20);
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
